@@ rtl/mtm_pkg.sv @@
// shared types, constants and pixel helper functions for the masked template match
package mtm_pkg;

    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int          CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int          OUT_CNT_W  = 21;
    localparam int          RATIO_W    = 9;
    localparam int          PROD_W     = CNT_W + RATIO_W;
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RATIO    = 2'd3;

    localparam logic [7:0]         TOLERANCE_RST   = 8'd16;
    localparam logic [7:0]         SAT_THRESH_RST  = 8'd60;
    localparam logic [7:0]         BRIGHT_RST      = 8'd200;
    localparam logic [RATIO_W-1:0] MATCH_RATIO_RST = 9'd230;

    typedef struct packed {
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
        logic [7:0] ref_red;
        logic [7:0] ref_green;
        logic [7:0] ref_blue;
        logic       last_pixel;
    } pixel_pair_t;

    typedef struct packed {
        logic                 is_match;
        logic                 used_fallback;
        logic [OUT_CNT_W-1:0] foreground_pixels;
        logic [OUT_CNT_W-1:0] matched_pixels;
    } match_result_t;

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/masked_template_match.sv @@
// masked template match: per-pixel foreground/tolerance counting and frame-end ratio test
// result path: input register, stage-2 totals register, then the output register
// throughput: one pixel pair per clock; a stalled output holds back a frame's last pixel
// the input register, counter update and frame-end multiply/compare stage are split by registers
// reset: counters clear to zero, the all-within flag sets, registers take their defaults
// (tolerance 16, spread 60, brightness 200, ratio 230); no result is pending
module masked_template_match
    import mtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pixel_pair_t           in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output match_result_t         out_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    // configuration
    logic [7:0]         tolerance_reg;
    logic [7:0]         sat_thresh_reg;
    logic [7:0]         bright_thresh_reg;
    logic [RATIO_W-1:0] ratio_reg;

    // stage 1: input register
    logic        s1_valid_reg, s1_valid_next;
    pixel_pair_t s1_data_reg;

    // running frame state
    logic [CNT_W-1:0] fg_cnt_reg, fg_cnt_next;
    logic [CNT_W-1:0] match_cnt_reg, match_cnt_next;
    logic             all_within_reg, all_within_next;

    // stage 2: frame totals waiting for the decision
    logic             s2_valid_reg, s2_valid_next;
    logic [CNT_W-1:0] s2_fg_reg;
    logic [CNT_W-1:0] s2_match_reg;
    logic             s2_all_within_reg;

    // output register
    logic          out_valid_reg, out_valid_next;
    match_result_t out_data_reg;

    logic             in_fire, s1_go, s1_to_s2, s2_move, out_free, s2_free;
    logic [7:0]       hi, lo;
    logic             is_fg, in_tol;
    logic [CNT_W-1:0] fg_upd, match_upd;
    logic [PROD_W-1:0] lhs, rhs;
    match_result_t    result;

    // handshake chain
    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        s2_move   = s2_valid_reg && out_free;
        s2_free   = !s2_valid_reg || out_free;
        s1_go     = s1_valid_reg && (!s1_data_reg.last_pixel || s2_free);
        s1_to_s2  = s1_go && s1_data_reg.last_pixel;
        in_ready  = !s1_valid_reg || s1_go;
        in_fire   = in_valid && in_ready;

        s1_valid_next  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_to_s2 ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
        out_valid_next = s2_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // per-pixel classification and counter update
    always_comb
    begin
        hi = max3(s1_data_reg.ref_red, s1_data_reg.ref_green, s1_data_reg.ref_blue);
        lo = min3(s1_data_reg.ref_red, s1_data_reg.ref_green, s1_data_reg.ref_blue);
        is_fg  = ((hi - lo) >= sat_thresh_reg) || (hi >= bright_thresh_reg);
        in_tol = (absdiff(s1_data_reg.cur_red,   s1_data_reg.ref_red)   <= tolerance_reg) &&
                 (absdiff(s1_data_reg.cur_green, s1_data_reg.ref_green) <= tolerance_reg) &&
                 (absdiff(s1_data_reg.cur_blue,  s1_data_reg.ref_blue)  <= tolerance_reg);

        fg_upd    = fg_cnt_reg;
        match_upd = match_cnt_reg;
        if (is_fg)
        begin
            fg_upd = (fg_cnt_reg < MAX_CNT) ? (fg_cnt_reg + 1'b1) : MAX_CNT;
            if (in_tol)
                match_upd = (match_cnt_reg < MAX_CNT) ? (match_cnt_reg + 1'b1) : MAX_CNT;
        end

        fg_cnt_next     = fg_cnt_reg;
        match_cnt_next  = match_cnt_reg;
        all_within_next = all_within_reg;
        if (s1_go)
        begin
            if (s1_data_reg.last_pixel)
            begin
                // frame closes: totals move to stage 2, counters restart
                fg_cnt_next     = '0;
                match_cnt_next  = '0;
                all_within_next = 1'b1;
            end
            else
            begin
                fg_cnt_next     = fg_upd;
                match_cnt_next  = match_upd;
                all_within_next = all_within_reg && in_tol;
            end
        end
    end

    // frame-end decision: matched * 256 >= ratio * foreground; with no foreground the all-within flag decides
    always_comb
    begin
        lhs = PROD_W'({s2_match_reg, 8'd0});
        rhs = PROD_W'(ratio_reg) * PROD_W'(s2_fg_reg);
        result.used_fallback     = (s2_fg_reg == '0);
        result.is_match          = result.used_fallback ? s2_all_within_reg : (lhs >= rhs);
        result.foreground_pixels = OUT_CNT_W'(s2_fg_reg);
        result.matched_pixels    = OUT_CNT_W'(s2_match_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg     <= TOLERANCE_RST;
            sat_thresh_reg    <= SAT_THRESH_RST;
            bright_thresh_reg <= BRIGHT_RST;
            ratio_reg         <= MATCH_RATIO_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TOLERANCE:     tolerance_reg     <= cfg_data[7:0];
                CFG_SAT_THRESHOLD: sat_thresh_reg    <= cfg_data[7:0];
                CFG_BRIGHT_THRESH: bright_thresh_reg <= cfg_data[7:0];
                CFG_MATCH_RATIO:   ratio_reg         <= cfg_data[RATIO_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fg_cnt_reg     <= '0;
            match_cnt_reg  <= '0;
            all_within_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
            fg_cnt_reg     <= fg_cnt_next;
            match_cnt_reg  <= match_cnt_next;
            all_within_reg <= all_within_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_data_reg <= in_data;
        if (s1_to_s2)
        begin
            s2_fg_reg         <= fg_upd;
            s2_match_reg      <= match_upd;
            s2_all_within_reg <= all_within_reg && in_tol;
        end
        if (s2_move)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/mtm_checker.sv @@
// port-level checks for the masked template match, bound to the top level
module mtm_checker
    import mtm_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input match_result_t out_data
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // fallback exactly when no foreground pixel was counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.used_fallback == (out_data.foreground_pixels == '0)))
        else $error("fallback flag disagrees with foreground count");

    // matched pixels are a subset of foreground pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.matched_pixels <= out_data.foreground_pixels))
        else $error("matched count above foreground count");

    // with a fallback there is nothing matched either
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.used_fallback |-> (out_data.matched_pixels == '0))
        else $error("matched pixels reported without foreground");

endmodule

bind masked_template_match mtm_checker u_mtm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
